// ===== src/periodic_waveform_generator_macros.svh =====
// ----------------------------------------------------------------------------
// periodic_waveform_generator_macros
// Assertion helper macros for the periodic waveform generator.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_WAVEFORM_GENERATOR_MACROS_SVH
`define PERIODIC_WAVEFORM_GENERATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PWG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PWG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/pwg_pkg.sv =====
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared constants and helpers for the periodic waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none
package pwg_pkg;
  localparam int unsigned SampleWidth = 8;
  localparam int unsigned PosWidth    = 12;
  localparam int unsigned LenWidth    = 13;
  localparam int unsigned CfgWidth    = 14;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned IndexWidth  = 12;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_TRI    = 2'd2;
  localparam logic [1:0] WAVE_SQUARE = 2'd3;

  localparam logic [1:0] REG_WAVE = 2'd0;
  localparam logic [1:0] REG_RATE = 2'd1;
  localparam logic [1:0] REG_FREQ = 2'd2;

  localparam logic [13:0] FREQ_MIN = 14'd16;
  localparam logic [13:0] FREQ_MAX = 14'd16000;
  localparam logic [15:0] CORDIC_X0 = 16'd19899;
  localparam logic [16:0] HALF_PI_Q16 = 17'd102944;

  function automatic logic [15:0] rate_value(input logic [1:0] sel);
    case (sel)
      2'd0:    rate_value = 16'd50066;
      2'd1:    rate_value = 16'd25033;
      2'd2:    rate_value = 16'd12517;
      default: rate_value = 16'd6258;
    endcase
  endfunction

  function automatic logic [15:0] atan_value(input logic [3:0] k);
    case (k)
      4'd0:    atan_value = 16'd51472;
      4'd1:    atan_value = 16'd30386;
      4'd2:    atan_value = 16'd16055;
      4'd3:    atan_value = 16'd8150;
      4'd4:    atan_value = 16'd4091;
      4'd5:    atan_value = 16'd2047;
      4'd6:    atan_value = 16'd1024;
      4'd7:    atan_value = 16'd512;
      4'd8:    atan_value = 16'd256;
      4'd9:    atan_value = 16'd128;
      4'd10:   atan_value = 16'd64;
      4'd11:   atan_value = 16'd32;
      4'd12:   atan_value = 16'd16;
      4'd13:   atan_value = 16'd8;
      4'd14:   atan_value = 16'd4;
      default: atan_value = 16'd2;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== src/pwg_stream_if.sv =====
// ----------------------------------------------------------------------------
// pwg_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none
interface pwg_stream_if #(parameter int unsigned WIDTH = 1);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/pwg_divider.sv =====
// ----------------------------------------------------------------------------
// pwg_divider
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pwg_divider #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot,
  output logic [DW-1:0]      rem
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [CW-1:0] count;
  logic          busy;
  logic [DW-1:0] dsr;
  logic [DW:0]   trial;

  assign trial = {rem, quot[NW-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CW'(NW);
      quot <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      // Shift one numerator bit into the partial remainder.
      if (trial >= {1'b0, dsr}) begin
        rem <= DW'(trial - {1'b0, dsr});
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/pwg_cordic.sv =====
// ----------------------------------------------------------------------------
// pwg_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pwg_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [18:0] angle,
  output logic                    done,
  output logic signed [17:0]      xo,
  output logic signed [17:0]      yo
);
  import pwg_pkg::*;
  logic [3:0]         k;
  logic               busy;
  logic signed [18:0] z;
  logic signed [17:0] dx, dy;

  assign dx = yo >>> k;
  assign dy = xo >>> k;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      k <= '0;
    end else if (start) begin
      busy <= 1'b1;
      k <= '0;
      xo <= 18'(CORDIC_X0);
      yo <= '0;
      z <= angle;
    end else if (busy) begin
      if (!z[18]) begin
        xo <= xo - dx;
        yo <= yo + dy;
        z <= z - 19'(atan_value(k));
      end else begin
        xo <= xo + dx;
        yo <= yo - dy;
        z <= z + 19'(atan_value(k));
      end
      k <= k + 1'b1;
      if (k == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/periodic_waveform_generator.sv =====
// ----------------------------------------------------------------------------
// periodic_waveform_generator
// Sine, sawtooth, triangle and square sample source.
// ----------------------------------------------------------------------------
// Usage: each transaction on the input channel (payload: restart) yields one
// transaction on the output channel carrying sample, position, period_end
// and period_length. Configuration writes (wave, rate, frequency) go through
// the plain write port while the block is idle.
// The period takes one 32-step serial division; ramps add a second one for
// the wave value, sine adds one for the angle plus a 16-step CORDIC.
// One item is in flight at a time; the input is ready when the core is idle,
// even while a finished result waits in the output register.
// Reset clears the configuration to sine, rate 50066, 440 Hz, and the
// position to zero. A stalled receiver holds the result register; the next
// item is computed and then waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_waveform_generator_macros.svh"
module periodic_waveform_generator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [pwg_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire logic [pwg_pkg::CfgWidth-1:0] cfg_data,
  pwg_stream_if.sink                        in_ch,
  pwg_stream_if.source                      out_ch
);
  import pwg_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PER   = 4'd1;
  localparam logic [3:0] ST_PERW  = 4'd2;
  localparam logic [3:0] ST_RAMP  = 4'd3;
  localparam logic [3:0] ST_RAMPW = 4'd4;
  localparam logic [3:0] ST_ANG   = 4'd5;
  localparam logic [3:0] ST_ANGW  = 4'd6;
  localparam logic [3:0] ST_CORW  = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [1:0]  wave_select;
  logic [1:0]  rate_select;
  logic [13:0] tone_frequency;
  logic [IndexWidth-1:0] phase_index;
  logic [3:0]  state;
  logic        restart_q;

  logic        div_start, div_done;
  logic [31:0] div_num, div_quot;
  logic [16:0] div_den, div_rem;
  logic        cor_start, cor_done;
  logic signed [18:0] cor_angle;
  logic signed [17:0] cor_x, cor_y;

  logic [12:0] n_len, half;
  logic [IndexWidth-1:0] pos;
  logic [1:0]  quad;
  logic signed [17:0] s_val;
  logic        neg_num;
  logic signed [7:0] smp;
  logic        out_full;
  logic [33:0] out_data;

  logic [13:0] f_clamped;
  logic [15:0] per;
  logic [15:0] n_raw;
  logic [12:0] n_new;
  logic [IndexWidth-1:0] pos_new;
  logic [13:0] i4;
  logic [12:0] ramp_j, ramp_len;
  logic signed [22:0] ramp_numer;
  logic signed [25:0] sine_numer;
  logic signed [8:0]  ramp_q;

  pwg_divider #(.NW(32), .DW(17)) u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );
  pwg_cordic u_cordic (
    .clk, .rst, .start(cor_start), .angle(cor_angle),
    .done(cor_done), .xo(cor_x), .yo(cor_y)
  );

  always_comb begin
    f_clamped = tone_frequency;
    if (tone_frequency < FREQ_MIN) f_clamped = FREQ_MIN;
    if (tone_frequency > FREQ_MAX) f_clamped = FREQ_MAX;
    per = div_quot[15:0];
    if (wave_select == WAVE_TRI || wave_select == WAVE_SQUARE) begin
      n_raw = {per[15:1] + {14'd0, per[1]}, 1'b0};
    end else begin
      n_raw = per + {15'd0, per[0]};
    end
    n_new = (n_raw < 16'd2) ? 13'd2 : n_raw[12:0];
    pos_new = restart_q ? '0 : phase_index;
    if ({{(16-IndexWidth){1'b0}}, pos_new} >= {3'd0, n_new}) pos_new = '0;
    i4 = {pos[11:0], 2'b00};
    // Triangle folds the second half back onto the rising ramp.
    if (wave_select == WAVE_TRI) begin
      ramp_len = half;
      ramp_j = (13'(pos) < half) ? 13'(pos) : 13'(n_len - 13'(pos));
    end else begin
      ramp_len = n_len;
      ramp_j = 13'(pos);
    end
    ramp_numer = 23'(21'(ramp_j) * 21'd255) - 23'({ramp_len, 7'd0});
    case (quad)
      2'd0:    s_val = cor_y;
      2'd1:    s_val = cor_x;
      2'd2:    s_val = -cor_y;
      default: s_val = -cor_x;
    endcase
    sine_numer = 26'(s_val) * 26'sd127 - 26'sd32768;
    ramp_q = div_quot[8:0];
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    cor_start <= 1'b0;
    if (rst) begin
      wave_select <= '0;
      rate_select <= '0;
      tone_frequency <= 14'd440;
      phase_index <= '0;
      state <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WAVE: wave_select <= cfg_data[1:0];
          REG_RATE: rate_select <= cfg_data[1:0];
          REG_FREQ: tone_frequency <= cfg_data;
          default: ;
        endcase
      end
      // Load the result register, or drop it once the receiver takes it.
      if (state == ST_OUT && (!out_full || out_ch.ready)) begin
        out_full <= 1'b1;
      end else if (out_full && out_ch.ready) begin
        out_full <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            restart_q <= in_ch.data[0];
            state <= ST_PER;
          end
        end
        ST_PER: begin
          div_num <= {16'd0, rate_value(rate_select)};
          div_den <= {3'd0, f_clamped};
          div_start <= 1'b1;
          state <= ST_PERW;
        end
        ST_PERW: begin
          if (div_done) begin
            n_len <= n_new;
            half <= {1'b0, n_new[12:1]};
            pos <= pos_new;
            if (wave_select == WAVE_SQUARE) begin
              smp <= (13'(pos_new) < {1'b0, n_new[12:1]}) ? 8'sd127 : -8'sd128;
              state <= ST_OUT;
            end else if (wave_select == WAVE_SINE) begin
              state <= ST_ANG;
            end else begin
              state <= ST_RAMP;
            end
          end
        end
        ST_RAMP: begin
          neg_num <= ramp_numer[22];
          div_num <= 32'(ramp_numer[22] ? -ramp_numer : ramp_numer);
          div_den <= {4'd0, ramp_len};
          div_start <= 1'b1;
          state <= ST_RAMPW;
        end
        ST_RAMPW: begin
          if (div_done) begin
            smp <= 8'(neg_num ? -ramp_q : ramp_q);
            state <= ST_OUT;
          end
        end
        ST_ANG: begin
          // Quadrant by compare-subtract, remainder angle by division.
          if ({1'b0, i4} >= 15'({n_len, 1'b0}) + 15'(n_len)) begin
            quad <= 2'd3;
            div_num <= 32'(34'(i4 - 14'(n_len) * 14'd3) * 34'(HALF_PI_Q16));
          end else if ({1'b0, i4} >= 15'({n_len, 1'b0})) begin
            quad <= 2'd2;
            div_num <= 32'(34'(i4 - 14'({n_len, 1'b0})) * 34'(HALF_PI_Q16));
          end else if (i4 >= 14'(n_len)) begin
            quad <= 2'd1;
            div_num <= 32'(34'(i4 - 14'(n_len)) * 34'(HALF_PI_Q16));
          end else begin
            quad <= 2'd0;
            div_num <= 32'(34'(i4) * 34'(HALF_PI_Q16));
          end
          div_den <= {4'd0, n_len};
          div_start <= 1'b1;
          state <= ST_ANGW;
        end
        ST_ANGW: begin
          if (div_done) begin
            cor_angle <= 19'(div_quot[17:0]);
            cor_start <= 1'b1;
            state <= ST_CORW;
          end
        end
        ST_CORW: begin
          if (cor_done) state <= ST_SCALE;
        end
        ST_SCALE: begin
          // Divide by 32768 toward zero, then saturate.
          if (sine_numer < 0) begin
            if (-sine_numer >= 26'sd4227072) smp <= -8'sd128;
            else smp <= 8'(-((-sine_numer) >>> 15));
          end else begin
            if (sine_numer >= 26'sd4194304) smp <= 8'sd127;
            else smp <= 8'(sine_numer >>> 15);
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_full || out_ch.ready) begin
            out_data <= {smp, 12'(pos), 13'(pos) == n_len - 13'd1, n_len};
            phase_index <= (13'(pos) == n_len - 13'd1) ? '0 : pos + 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = out_full;
  assign out_ch.data = out_data;

  `PWG_ASSERT_IMP(a_idle_when_ready, in_ch.ready, state == ST_IDLE, "ready outside idle")
  `PWG_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state == ST_PER,
    "accept did not start work")
  `PWG_ASSERT_IMP(a_len_even, out_ch.valid, out_ch.data[0] == 1'b0 && out_ch.data[12:1] != 0,
    "period not even or too short")
  `PWG_ASSERT_IMP(a_pos_in_range, out_ch.valid, out_ch.data[25:14] < out_ch.data[12:0],
    "position beyond period")
endmodule
`default_nettype wire
